FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the monitor RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge, ignored while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// Checked at every clock edge, including during reset.
`define ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`endif

FILE: design/tmrdm_pkg.sv
// ----------------------------------------------------------------------------
// tmrdm_pkg
// Types and constants shared by the TMR disagreement monitor modules.
// ----------------------------------------------------------------------------
package tmrdm_pkg;

   localparam int NUM_CH   = 3;
   localparam int WORD_W   = 64;
   localparam int CNT_W    = 8;
   localparam int FLAG_W   = NUM_CH;

   localparam logic [CNT_W-1:0] COUNT_MAX           = 8'hFF;
   localparam logic [CNT_W-1:0] PERSIST_LIMIT_RESET = 8'd10;

   typedef struct packed {
      logic [WORD_W-1:0] out_word_a;
      logic [WORD_W-1:0] out_word_b;
      logic [WORD_W-1:0] out_word_c;
      logic [WORD_W-1:0] rin_word_a;
      logic [WORD_W-1:0] rin_word_b;
      logic [WORD_W-1:0] rin_word_c;
      logic [FLAG_W-1:0] bus1_err;
      logic [FLAG_W-1:0] bus2_err;
   } req_type;

   typedef struct packed {
      logic [FLAG_W-1:0] lost_flags;
      logic [FLAG_W-1:0] logic_flags;
      logic [FLAG_W-1:0] remote_flags;
      logic [FLAG_W-1:0] board_flags;
      logic [WORD_W-1:0] kept_out_a;
      logic [WORD_W-1:0] kept_out_b;
      logic [WORD_W-1:0] kept_out_c;
      logic              clear_remote_buf;
   } rsp_type;

   // Controls handed to each persistence counter bank.
   typedef struct packed {
      logic advance;   // item moves from the input register to the result register
      logic online;    // no channel lost in this item
   } persist_ctl_type;

endpackage

FILE: design/tmrdm_vote.sv
// ----------------------------------------------------------------------------
// tmrdm_vote
// Flags each channel whose word differs from both other channels' words.
// ----------------------------------------------------------------------------
module tmrdm_vote (
   input  logic [tmrdm_pkg::WORD_W-1:0] word_a,
   input  logic [tmrdm_pkg::WORD_W-1:0] word_b,
   input  logic [tmrdm_pkg::WORD_W-1:0] word_c,
   output logic [tmrdm_pkg::FLAG_W-1:0] odd
);
   import tmrdm_pkg::*;

   logic eq_ab;
   logic eq_bc;
   logic eq_ca;

   assign eq_ab = (word_a == word_b);
   assign eq_bc = (word_b == word_c);
   assign eq_ca = (word_c == word_a);

   assign odd[0] = !eq_ab && !eq_ca;
   assign odd[1] = !eq_ab && !eq_bc;
   assign odd[2] = !eq_bc && !eq_ca;

endmodule

FILE: design/tmrdm_persist.sv
// ----------------------------------------------------------------------------
// tmrdm_persist
// Per-channel saturating disagreement counters and fault compare.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tmrdm_persist (
   input  logic                           clock,
   input  logic                           reset,
   input  tmrdm_pkg::persist_ctl_type     ctl,
   input  logic [tmrdm_pkg::FLAG_W-1:0]   odd,
   input  logic [tmrdm_pkg::CNT_W-1:0]    limit,
   output logic [tmrdm_pkg::FLAG_W-1:0]   fault
);
   import tmrdm_pkg::*;

   logic [CNT_W-1:0] count_ff [NUM_CH];
   logic [CNT_W-1:0] count_in [NUM_CH];
   logic [FLAG_W-1:0] grow;

   always_comb begin
      for (int i = 0; i < NUM_CH; i++) begin
         grow[i] = ctl.online && odd[i];
         if (!grow[i]) begin
            count_in[i] = '0;
         end else if (count_ff[i] == COUNT_MAX) begin
            count_in[i] = COUNT_MAX;
         end else begin
            count_in[i] = count_ff[i] + CNT_W'(1);
         end
         // fault follows the count after this item's update
         fault[i] = (count_in[i] > limit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CH; i++) begin
            count_ff[i] <= '0;
         end
      end else if (ctl.advance) begin
         for (int i = 0; i < NUM_CH; i++) begin
            count_ff[i] <= count_in[i];
         end
      end
   end

   `ASSERT_CLK_RST(a_offline_clears, clock, reset, (ctl.advance && !ctl.online) |=> (count_ff[0] == '0 && count_ff[1] == '0 && count_ff[2] == '0))
   `ASSERT_CLK_RST(a_saturate, clock, reset, (ctl.advance && grow[0] && count_ff[0] == COUNT_MAX) |=> (count_ff[0] == COUNT_MAX))
   `ASSERT_CLK_RST(a_hold_idle, clock, reset, !ctl.advance |=> ($stable(count_ff[0]) && $stable(count_ff[1]) && $stable(count_ff[2])))

endmodule

FILE: design/tmr_channel_disagreement_monitor_core.sv
// ----------------------------------------------------------------------------
// tmr_channel_disagreement_monitor_core
// Triple-redundant channel disagreement monitor with persistence filtering.
// ----------------------------------------------------------------------------
// One monitoring tick is one req item; each yields exactly one rsp item. An
// item is captured in an input register, evaluated by the comparators and the
// counter banks while it is held there, and its result lands in the result register
// when the item advances, with rsp_valid rising alongside it. One item per cycle
// is sustained while rsp_stall stays low; the input register can still take one
// item while a result waits on rsp_stall, and req_stall rises only when both
// registers are full. The persistence counters advance as an item moves into the result
// register. csr_ready is always high; persist_limit resets to 10 and should
// only be written while no item is in flight.
`include "assert_macros.svh"

module tmr_channel_disagreement_monitor_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  tmrdm_pkg::req_type             req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output tmrdm_pkg::rsp_type             rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tmrdm_pkg::CNT_W-1:0]    csr_wdata
);
   import tmrdm_pkg::*;

   logic                in_valid_ff;
   logic                in_valid_in;
   req_type             in_data_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   rsp_type             rsp_data_ff;
   rsp_type             rsp_data_in;
   logic [CNT_W-1:0]    limit_ff;

   logic                out_free;
   logic                advance;
   logic                req_accept;
   logic [FLAG_W-1:0]   lost;
   logic [FLAG_W-1:0]   out_odd;
   logic [FLAG_W-1:0]   rin_odd;
   logic [FLAG_W-1:0]   logic_fault;
   logic [FLAG_W-1:0]   remote_fault;
   logic [FLAG_W-1:0]   drop;
   persist_ctl_type     ctl;

   // handshake
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // evaluation
   assign lost       = in_data_ff.bus1_err & in_data_ff.bus2_err;
   assign ctl.advance = advance;
   assign ctl.online  = (lost == '0);

   tmrdm_vote u_out_vote (
      .word_a (in_data_ff.out_word_a),
      .word_b (in_data_ff.out_word_b),
      .word_c (in_data_ff.out_word_c),
      .odd    (out_odd)
   );

   tmrdm_vote u_rin_vote (
      .word_a (in_data_ff.rin_word_a),
      .word_b (in_data_ff.rin_word_b),
      .word_c (in_data_ff.rin_word_c),
      .odd    (rin_odd)
   );

   tmrdm_persist u_out_persist (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .odd   (out_odd),
      .limit (limit_ff),
      .fault (logic_fault)
   );

   tmrdm_persist u_rin_persist (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .odd   (rin_odd),
      .limit (limit_ff),
      .fault (remote_fault)
   );

   assign drop = lost | logic_fault;

   always_comb begin
      rsp_data_in.lost_flags       = lost;
      rsp_data_in.logic_flags      = logic_fault;
      rsp_data_in.remote_flags     = remote_fault;
      rsp_data_in.board_flags      = in_data_ff.bus1_err | in_data_ff.bus2_err | lost
                                     | logic_fault | remote_fault;
      rsp_data_in.kept_out_a       = drop[0] ? '0 : in_data_ff.out_word_a;
      rsp_data_in.kept_out_b       = drop[1] ? '0 : in_data_ff.out_word_b;
      rsp_data_in.kept_out_c       = drop[2] ? '0 : in_data_ff.out_word_c;
      rsp_data_in.clear_remote_buf = (lost != '0) || (remote_fault != '0);
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= PERSIST_LIMIT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `ASSERT_CLK(a_reset_empty, clock, reset |=> (!rsp_valid_ff && !in_valid_ff))
   `ASSERT_CLK_RST(a_lost_clears_buf, clock, reset, (rsp_valid_ff && rsp_data_ff.lost_flags != '0) |-> rsp_data_ff.clear_remote_buf)
   `ASSERT_CLK_RST(a_drop_a_zero, clock, reset, (rsp_valid_ff && (rsp_data_ff.lost_flags[0] || rsp_data_ff.logic_flags[0])) |-> (rsp_data_ff.kept_out_a == '0))
   `ASSERT_CLK_RST(a_advance_fills, clock, reset, advance |=> rsp_valid_ff)

endmodule

FILE: tb/tb_tmr_channel_disagreement_monitor_core.sv
// ----------------------------------------------------------------------------
// tb_tmr_channel_disagreement_monitor_core
// Self-checking bench for the TMR channel disagreement monitor. Ticks are
// queued by a stimulus process and driven with random gaps. Each accepted
// tick is run through a local model of the persistence counters, and every
// result is compared field by field, in order, against that prediction.
// ----------------------------------------------------------------------------
module tb_tmr_channel_disagreement_monitor_core;
   import tmrdm_pkg::*;

   typedef logic [NUM_CH-1:0][WORD_W-1:0] word_set_t;

   typedef enum logic [2:0] {
      PAT_SAME, PAT_ODD_A, PAT_ODD_B, PAT_ODD_C, PAT_ALL_DIFF
   } word_pattern_e;

   typedef enum logic [1:0] {
      RUN_MIXED, RUN_CLEAN_ODD, RUN_NOISE
   } run_kind_e;

   localparam int HOLD_CYCLES = 150;
   localparam int MAX_PRINTS  = 50;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CNT_W-1:0]  csr_wdata = '0;

   // model state
   logic [CNT_W-1:0]  persist_limit_q = PERSIST_LIMIT_RESET;
   logic [CNT_W-1:0]  out_persist [NUM_CH] = '{default: '0};
   logic [CNT_W-1:0]  rin_persist [NUM_CH] = '{default: '0};

   req_type           tick_q[$];
   rsp_type           expected_reports[$];

   int                mismatch_count = 0;
   int                send_gap = 0;
   int                stall_left = 0;
   int                hold_left = 0;
   int                holds_asked = 0;
   int                holds_served = 0;
   bit                send_gaps_on = 1'b1;
   bit                recv_gaps_on = 1'b1;

   tmr_channel_disagreement_monitor_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- model
   function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c, bit grow);
      if (!grow) return '0;
      return (c == COUNT_MAX) ? COUNT_MAX : c + 1'b1;
   endfunction

   function automatic bit odd_one(word_set_t w, int i);
      return w[i] != w[(i + 1) % NUM_CH] && w[i] != w[(i + 2) % NUM_CH];
   endfunction

   function automatic rsp_type monitor_tick(req_type t);
      word_set_t         ow;
      word_set_t         rw;
      logic [FLAG_W-1:0] lost;
      logic [FLAG_W-1:0] fault_logic;
      logic [FLAG_W-1:0] fault_remote;
      logic [FLAG_W-1:0] dropped;
      bit                online;
      rsp_type           r;
      ow = {t.out_word_c, t.out_word_b, t.out_word_a};
      rw = {t.rin_word_c, t.rin_word_b, t.rin_word_a};
      lost = t.bus1_err & t.bus2_err;
      online = (lost == '0);
      fault_logic = '0;
      fault_remote = '0;
      // comparisons always see the raw words of this tick
      for (int i = 0; i < NUM_CH; i++) begin
         out_persist[i] = bump(out_persist[i], online && odd_one(ow, i));
         rin_persist[i] = bump(rin_persist[i], online && odd_one(rw, i));
         fault_logic[i] = out_persist[i] > persist_limit_q;
         fault_remote[i] = rin_persist[i] > persist_limit_q;
      end
      dropped = lost | fault_logic;
      r.lost_flags = lost;
      r.logic_flags = fault_logic;
      r.remote_flags = fault_remote;
      r.board_flags = t.bus1_err | t.bus2_err | lost | fault_logic | fault_remote;
      r.kept_out_a = dropped[0] ? '0 : ow[0];
      r.kept_out_b = dropped[1] ? '0 : ow[1];
      r.kept_out_c = dropped[2] ? '0 : ow[2];
      r.clear_remote_buf = (lost != '0) || (fault_remote != '0);
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   function automatic logic [WORD_W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [WORD_W-1:0] pick_word();
      int r;
      r = $urandom_range(0, 99);
      if (r < 6) return '0;
      if (r < 12) return '1;
      return rand_word();
   endfunction

   function automatic logic [WORD_W-1:0] other_word(logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] x;
      x = pick_word();
      return (x == w) ? ~w : x;
   endfunction

   function automatic word_set_t make_words(word_pattern_e p);
      word_set_t w;
      w[0] = pick_word();
      w[1] = w[0];
      w[2] = w[0];
      case (p)
         PAT_ODD_A: w[0] = other_word(w[0]);
         PAT_ODD_B: w[1] = other_word(w[0]);
         PAT_ODD_C: w[2] = other_word(w[0]);
         PAT_ALL_DIFF: begin
            w[1] = other_word(w[0]);
            w[2] = pick_word();
            while (w[2] == w[0] || w[2] == w[1]) w[2] = rand_word();
         end
         default: ;
      endcase
      return w;
   endfunction

   task automatic push_tick(word_set_t ow, word_set_t rw, logic [FLAG_W-1:0] b1,
                            logic [FLAG_W-1:0] b2);
      req_type t;
      t.out_word_a = ow[0];
      t.out_word_b = ow[1];
      t.out_word_c = ow[2];
      t.rin_word_a = rw[0];
      t.rin_word_b = rw[1];
      t.rin_word_c = rw[2];
      t.bus1_err = b1;
      t.bus2_err = b2;
      tick_q.push_back(t);
   endtask

   // A clean or mixed run holds one disagreement pattern for a stretch of ticks so counters
   // can actually reach the limit; mixed runs get the odd broken tick, noise runs re-pick every tick.
   task automatic queue_run(int len, run_kind_e kind);
      word_pattern_e     pat_o;
      word_pattern_e     pat_r;
      word_pattern_e     po;
      word_pattern_e     pr;
      logic [FLAG_W-1:0] b1;
      logic [FLAG_W-1:0] b2;
      int                r;
      if (kind == RUN_CLEAN_ODD) begin
         pat_o = word_pattern_e'($urandom_range(PAT_ODD_A, PAT_ALL_DIFF));
         pat_r = word_pattern_e'($urandom_range(PAT_ODD_A, PAT_ALL_DIFF));
      end else begin
         pat_o = word_pattern_e'($urandom_range(PAT_SAME, PAT_ALL_DIFF));
         pat_r = word_pattern_e'($urandom_range(PAT_SAME, PAT_ALL_DIFF));
      end
      for (int k = 0; k < len; k++) begin
         po = pat_o;
         pr = pat_r;
         b1 = '0;
         b2 = '0;
         if (kind == RUN_NOISE || (kind == RUN_MIXED && $urandom_range(0, 99) < 5)) begin
            po = word_pattern_e'($urandom_range(PAT_SAME, PAT_ALL_DIFF));
            pr = word_pattern_e'($urandom_range(PAT_SAME, PAT_ALL_DIFF));
         end
         if (kind == RUN_NOISE) begin
            b1 = $urandom_range(0, 7);
            b2 = $urandom_range(0, 7);
         end else if (kind == RUN_MIXED) begin
            r = $urandom_range(0, 99);
            if (r >= 95) begin
               b1 = $urandom_range(0, 7);
               b2 = $urandom_range(0, 7);
            end else if (r >= 80) begin
               // single-bus faults only, nobody lost
               b1 = $urandom_range(0, 7);
               b2 = $urandom_range(0, 7) & ~b1;
            end
         end
         push_tick(make_words(po), make_words(pr), b1, b2);
      end
   endtask

   task automatic queue_random(int n);
      int made;
      int len;
      int cap;
      int r;
      made = 0;
      while (made < n) begin
         cap = (persist_limit_q > 30) ? 40 : int'(persist_limit_q) + 8;
         len = $urandom_range(1, cap);
         if (len > n - made) len = n - made;
         r = $urandom_range(0, 99);
         if (r < 10) queue_run(len, RUN_NOISE);
         else if (r < 20) queue_run(len, RUN_CLEAN_ODD);
         else queue_run(len, RUN_MIXED);
         made += len;
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (tick_q.size() != 0 || req_valid || expected_reports.size() != 0);
   endtask

   task automatic write_limit(logic [CNT_W-1:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      persist_limit_q = v;
   endtask

   task automatic report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
   endtask

   task automatic check_field(string name, logic [WORD_W-1:0] got,
                              logic [WORD_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h expected %h", name, got, want));
   endtask

   // ---------------------------------------------------------------- driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) expected_reports.push_back(monitor_tick(req_data));
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (tick_q.size() > 0) begin
               req_data <= tick_q.pop_front();
               req_valid <= 1'b1;
               if (send_gaps_on && $urandom_range(0, 99) < 25) send_gap = gap_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (holds_served != holds_asked) begin
         holds_served++;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (recv_gaps_on && $urandom_range(0, 99) < 20) begin
         stall_left = gap_len() - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            report_mismatch("result with no item pending");
         end else begin
            want = expected_reports.pop_front();
            check_field("lost_flags", rsp_data.lost_flags, want.lost_flags);
            check_field("logic_flags", rsp_data.logic_flags, want.logic_flags);
            check_field("remote_flags", rsp_data.remote_flags, want.remote_flags);
            check_field("board_flags", rsp_data.board_flags, want.board_flags);
            check_field("kept_out_a", rsp_data.kept_out_a, want.kept_out_a);
            check_field("kept_out_b", rsp_data.kept_out_b, want.kept_out_b);
            check_field("kept_out_c", rsp_data.kept_out_c, want.kept_out_c);
            check_field("clear_remote_buf", rsp_data.clear_remote_buf,
                        want.clear_remote_buf);
         end
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed ticks at the reset limit
      push_tick('0, '0, 3'b000, 3'b000);
      push_tick('1, '1, 3'b000, 3'b000);
      push_tick('1, '0, 3'b111, 3'b000);
      push_tick('0, '1, 3'b000, 3'b111);
      push_tick(make_words(PAT_ALL_DIFF), make_words(PAT_ALL_DIFF), 3'b111, 3'b111);
      for (int ch = 0; ch < NUM_CH; ch++)
         push_tick(make_words(PAT_ODD_A), make_words(PAT_ALL_DIFF), 3'(1 << ch),
                   3'(1 << ch));
      push_tick(make_words(PAT_ALL_DIFF), make_words(PAT_ODD_B), 3'b011, 3'b110);
      // A's output and C's remote word stay odd past the limit; once A is
      // zeroed, B and C must still be compared against A's raw word
      for (int k = 0; k < 13; k++)
         push_tick(make_words(PAT_ODD_A), make_words(PAT_ODD_C), 3'b000, 3'b000);
      push_tick(make_words(PAT_ALL_DIFF), make_words(PAT_ALL_DIFF), 3'b000, 3'b000);
      push_tick(make_words(PAT_ODD_A), make_words(PAT_ODD_C), 3'b001, 3'b001);
      push_tick(make_words(PAT_ODD_B), make_words(PAT_ODD_B), 3'b010, 3'b000);
      queue_random(200);
      wait_drained();

      // zero limit; receiver holds off long while the sender keeps offering
      write_limit(8'd0);
      send_gaps_on = 1'b0;
      holds_asked++;
      queue_random(200);
      wait_drained();
      send_gaps_on = 1'b1;

      // top of the range: fault only once the count saturates
      write_limit(8'd254);
      queue_run(300, RUN_CLEAN_ODD);
      wait_drained();
      queue_random(20);
      wait_drained();

      // a limit no count can exceed
      write_limit(8'd255);
      queue_run(270, RUN_CLEAN_ODD);
      queue_random(30);
      wait_drained();

      // back-to-back on both sides
      write_limit(8'd3);
      send_gaps_on = 1'b0;
      recv_gaps_on = 1'b0;
      queue_random(250);
      wait_drained();
      send_gaps_on = 1'b1;
      recv_gaps_on = 1'b1;

      write_limit(CNT_W'($urandom_range(1, 20)));
      queue_random(150);
      wait_drained();

      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && expected_reports.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

FILE: tmr_channel_disagreement_monitor_core.f
+incdir+design
design/tmrdm_pkg.sv
design/tmrdm_vote.sv
design/tmrdm_persist.sv
design/tmr_channel_disagreement_monitor_core.sv
tb/tb_tmr_channel_disagreement_monitor_core.sv
